>>> rtl/hgsc_pkg.sv
// shared types and constants for the hand gesture state classifier
package hgsc_pkg;

	localparam int RATIO_W  = 8;
	localparam int RADIUS_W = 10;
	localparam int THR_W    = RADIUS_W + RATIO_W;
	localparam int DIST_SHIFT = 2 * RATIO_W;

	localparam logic [1:0] CFG_MOVE_RATIO  = 2'd0;
	localparam logic [1:0] CFG_STILL_RATIO = 2'd1;
	localparam logic [1:0] CFG_PINCH_RATIO = 2'd2;

	localparam logic [RATIO_W-1:0] MOVE_RATIO_RST  = 8'd154;
	localparam logic [RATIO_W-1:0] STILL_RATIO_RST = 8'd51;
	localparam logic [RATIO_W-1:0] PINCH_RATIO_RST = 8'd128;

	localparam logic [2:0] OPEN_MIN_FINGERS = 3'd4;

	typedef enum logic [1:0] {
		MOT_MOVE    = 2'd0,
		MOT_STATION = 2'd1,
		MOT_START   = 2'd2
	} motion_t;

	typedef enum logic [2:0] {
		GES_OPEN    = 3'd0,
		GES_CLOSED  = 3'd1,
		GES_POINTER = 3'd2,
		GES_SCROLL  = 3'd3,
		GES_PINCH   = 3'd4
	} gesture_t;

	typedef struct packed {
		motion_t    motion;
		gesture_t   gesture;
		logic [1:0] top;
		logic [1:0] low;
	} hgsc_state_t;

endpackage

>>> rtl/hgsc_ser_mul.sv
// bit-serial shift-and-add multiplier, one multiplier bit per cycle
module hgsc_ser_mul import hgsc_pkg::*; #(
	parameter int MUL_W = 18
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [MUL_W-1:0]   mcand,
	input  logic [MUL_W-1:0]   mplier,
	output logic [2*MUL_W-1:0] product,
	output logic               done
);

	localparam int CNT_W = $clog2(MUL_W + 1);

	logic [2*MUL_W-1:0] p_q;
	logic [MUL_W-1:0]   mcand_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [MUL_W:0]     sum;

	assign sum = {1'b0, p_q[2*MUL_W-1:MUL_W]} + (p_q[0] ? {1'b0, mcand_q} : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(MUL_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			p_q     <= {{MUL_W{1'b0}}, mplier};
			mcand_q <= mcand;
		end else if (busy_q) begin
			p_q <= {sum, p_q[MUL_W-1:1]};
		end
	end

	assign product = p_q;
	assign done    = done_q;

endmodule

>>> rtl/hgsc_gesture.sv
// motion transition, finger ordering and gesture classification
module hgsc_gesture import hgsc_pkg::*; #(
	parameter int COORD_BITS = 11
) (
	input  logic                  still,
	input  logic [2:0]            finger_count,
	input  logic [COORD_BITS-1:0] height_a,
	input  logic [COORD_BITS-1:0] height_b,
	input  logic [COORD_BITS-1:0] height_c,
	input  logic [THR_W-1:0]      limit,
	input  hgsc_state_t           cur,
	output hgsc_state_t           nxt
);

	localparam int SPR_W = COORD_BITS + RATIO_W;
	localparam int PW    = (SPR_W > THR_W) ? SPR_W : THR_W;

	logic [COORD_BITS-1:0] h [3];
	logic [COORD_BITS-1:0] spread;
	logic [COORD_BITS-1:0] hmax;
	logic [COORD_BITS-1:0] hmin;
	logic [1:0]            hi_idx;
	logic [1:0]            lo_idx;
	logic                  pinch;
	gesture_t              cand;

	assign h[0] = height_a;
	assign h[1] = height_b;
	assign h[2] = height_c;

	// two fingers compare a and b only, three use the full spread
	assign spread = (finger_count == 3'd2)
		? ((height_a > height_b) ? height_a - height_b : height_b - height_a)
		: hmax - hmin;

	assign pinch = PW'({spread, {RATIO_W{1'b0}}}) > PW'(limit);

	always_comb begin
		hi_idx = 2'd0;
		hmax   = h[0];
		if (h[1] > hmax) begin
			hi_idx = 2'd1;
			hmax   = h[1];
		end
		if (h[2] > hmax) begin
			hi_idx = 2'd2;
			hmax   = h[2];
		end
		lo_idx = 2'd0;
		hmin   = h[0];
		if (h[1] < hmin) begin
			lo_idx = 2'd1;
			hmin   = h[1];
		end
		if (h[2] < hmin) begin
			lo_idx = 2'd2;
			hmin   = h[2];
		end
	end

	always_comb begin
		nxt = cur;
		if (cur.motion == MOT_STATION) begin
			nxt.motion = still ? MOT_STATION : MOT_START;
		end else begin
			nxt.motion = still ? MOT_STATION : MOT_MOVE;
		end
		cand = cur.gesture;
		if (nxt.motion == MOT_STATION) begin
			case (finger_count)
				3'd0: begin
					cand = GES_CLOSED;
				end
				3'd1: begin
					cand    = GES_POINTER;
					nxt.top = 2'd0;
				end
				3'd2: begin
					if (height_a > height_b) begin
						nxt.top = 2'd0;
						nxt.low = 2'd1;
					end else begin
						nxt.top = 2'd1;
						nxt.low = 2'd0;
					end
					cand = pinch ? GES_PINCH : GES_SCROLL;
				end
				3'd3: begin
					nxt.top = hi_idx;
					nxt.low = lo_idx;
					cand    = pinch ? GES_PINCH : GES_SCROLL;
				end
				default: begin
					cand = GES_OPEN;
				end
			endcase
		end
		if (cur.gesture != GES_OPEN && cand != cur.gesture) begin
			cand = GES_OPEN;
		end
		nxt.gesture = cand;
	end

endmodule

>>> rtl/hand_gesture_state_classifier_core.sv
// top level: frame capture, multiply sequencer, stillness test and state update
// a new frame is accepted only once the last one is decided; out_valid is
// registered after the decide step, which waits while out_stall holds a result
// five products (two thresholds, three squares) run one after another through one
// bit-serial multiplier, one bit per cycle, before the decide step
// reset clears the tracked center, motion, gesture and finger indices and
// loads the ratio registers with their defaults; no clearing pass
module hand_gesture_state_classifier_core import hgsc_pkg::*; #(
	parameter int COORD_BITS = 11
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [COORD_BITS-1:0] hand_x,
	input  logic [COORD_BITS-1:0] hand_y,
	input  logic [RADIUS_W-1:0]   hand_radius,
	input  logic [2:0]            finger_count,
	input  logic [COORD_BITS-1:0] height_a,
	input  logic [COORD_BITS-1:0] height_b,
	input  logic [COORD_BITS-1:0] height_c,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            gesture,
	output logic [1:0]            motion,
	output logic [COORD_BITS-1:0] track_x,
	output logic [COORD_BITS-1:0] track_y,
	output logic [1:0]            top_finger,
	output logic [1:0]            low_finger,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [1:0]            cfg_index,
	input  logic [RATIO_W-1:0]    cfg_data
);

	localparam int MUL_W = (COORD_BITS > THR_W) ? COORD_BITS : THR_W;
	localparam int SQ_W  = 2 * COORD_BITS;
	localparam int D2_W  = SQ_W + 1;
	localparam int CMP_W = (D2_W + DIST_SHIFT > 2 * THR_W) ? D2_W + DIST_SHIFT : 2 * THR_W;

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_LAUNCH = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_DECIDE = 4'b1000
	} state_t;

	typedef enum logic [2:0] {
		JOB_THR  = 3'd0,
		JOB_LIM  = 3'd1,
		JOB_THR2 = 3'd2,
		JOB_DX2  = 3'd3,
		JOB_DY2  = 3'd4
	} job_t;

	state_t st_q;
	job_t   job_q;

	logic [RATIO_W-1:0] move_ratio_q;
	logic [RATIO_W-1:0] still_ratio_q;
	logic [RATIO_W-1:0] pinch_ratio_q;

	logic [COORD_BITS-1:0] tracked_x_q;
	logic [COORD_BITS-1:0] tracked_y_q;
	hgsc_state_t           state_q;
	hgsc_state_t           state_d;
	logic                  out_valid_q;

	logic [COORD_BITS-1:0] x_q;
	logic [COORD_BITS-1:0] y_q;
	logic [RADIUS_W-1:0]   radius_q;
	logic [2:0]            count_q;
	logic [COORD_BITS-1:0] ha_q;
	logic [COORD_BITS-1:0] hb_q;
	logic [COORD_BITS-1:0] hc_q;
	logic [COORD_BITS-1:0] dx_q;
	logic [COORD_BITS-1:0] dy_q;
	logic [THR_W-1:0]      thr_q;
	logic [THR_W-1:0]      lim_q;
	logic [2*THR_W-1:0]    thr2_q;
	logic [SQ_W-1:0]       dx2_q;
	logic [SQ_W-1:0]       dy2_q;

	logic                  in_xfer;
	logic                  out_free;
	logic                  mul_start;
	logic                  mul_done;
	logic [MUL_W-1:0]      op_a;
	logic [MUL_W-1:0]      op_b;
	logic [2*MUL_W-1:0]    product;
	logic [D2_W-1:0]       d2;
	logic                  still;

	assign in_stall  = (st_q != ST_IDLE);
	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;
	assign mul_start = (st_q == ST_LAUNCH);

	always_comb begin
		case (job_q)
			JOB_THR: begin
				op_a = MUL_W'(radius_q);
				op_b = (state_q.motion == MOT_MOVE) ? MUL_W'(move_ratio_q)
				                                    : MUL_W'(still_ratio_q);
			end
			JOB_LIM: begin
				op_a = MUL_W'(radius_q);
				op_b = MUL_W'(pinch_ratio_q);
			end
			JOB_THR2: begin
				op_a = MUL_W'(thr_q);
				op_b = MUL_W'(thr_q);
			end
			JOB_DX2: begin
				op_a = MUL_W'(dx_q);
				op_b = MUL_W'(dx_q);
			end
			JOB_DY2: begin
				op_a = MUL_W'(dy_q);
				op_b = MUL_W'(dy_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	hgsc_ser_mul #(
		.MUL_W (MUL_W)
	) u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mul_start),
		.mcand   (op_a),
		.mplier  (op_b),
		.product (product),
		.done    (mul_done)
	);

	assign d2    = D2_W'(dx2_q) + D2_W'(dy2_q);
	assign still = CMP_W'({d2, {DIST_SHIFT{1'b0}}}) < CMP_W'(thr2_q);

	hgsc_gesture #(
		.COORD_BITS (COORD_BITS)
	) u_gesture (
		.still        (still),
		.finger_count (count_q),
		.height_a     (ha_q),
		.height_b     (hb_q),
		.height_c     (hc_q),
		.limit        (lim_q),
		.cur          (state_q),
		.nxt          (state_d)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			move_ratio_q  <= MOVE_RATIO_RST;
			still_ratio_q <= STILL_RATIO_RST;
			pinch_ratio_q <= PINCH_RATIO_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_MOVE_RATIO:  move_ratio_q  <= cfg_data;
				CFG_STILL_RATIO: still_ratio_q <= cfg_data;
				CFG_PINCH_RATIO: pinch_ratio_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// sequencer and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			job_q       <= JOB_THR;
			tracked_x_q <= '0;
			tracked_y_q <= '0;
			state_q     <= '{motion: MOT_MOVE, gesture: GES_OPEN, top: 2'd0, low: 2'd0};
			out_valid_q <= 1'b0;
		end else begin
			if (st_q == ST_DECIDE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (in_xfer) begin
						job_q <= JOB_THR;
						st_q  <= ST_LAUNCH;
					end
				end
				ST_LAUNCH: begin
					st_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (mul_done) begin
						case (job_q)
							JOB_THR:  job_q <= JOB_LIM;
							JOB_LIM:  job_q <= JOB_THR2;
							JOB_THR2: job_q <= JOB_DX2;
							JOB_DX2:  job_q <= JOB_DY2;
							default:  job_q <= JOB_THR;
						endcase
						st_q <= (job_q == JOB_DY2) ? ST_DECIDE : ST_LAUNCH;
					end
				end
				ST_DECIDE: begin
					if (out_free) begin
						state_q <= state_d;
						if (!still) begin
							tracked_x_q <= x_q;
							tracked_y_q <= y_q;
						end
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// frame capture and products
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			x_q      <= hand_x;
			y_q      <= hand_y;
			radius_q <= hand_radius;
			count_q  <= finger_count;
			ha_q     <= height_a;
			hb_q     <= height_b;
			hc_q     <= height_c;
			dx_q     <= (hand_x > tracked_x_q) ? hand_x - tracked_x_q : tracked_x_q - hand_x;
			dy_q     <= (hand_y > tracked_y_q) ? hand_y - tracked_y_q : tracked_y_q - hand_y;
		end
		if (st_q == ST_WAIT && mul_done) begin
			case (job_q)
				JOB_THR:  thr_q  <= product[THR_W-1:0];
				JOB_LIM:  lim_q  <= product[THR_W-1:0];
				JOB_THR2: thr2_q <= product[2*THR_W-1:0];
				JOB_DX2:  dx2_q  <= product[SQ_W-1:0];
				JOB_DY2:  dy2_q  <= product[SQ_W-1:0];
				default: ;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign gesture    = state_q.gesture;
	assign motion     = state_q.motion;
	assign track_x    = tracked_x_q;
	assign track_y    = tracked_y_q;
	assign top_finger = state_q.top;
	assign low_finger = state_q.low;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_done |-> st_q == ST_WAIT)
		else $error("multiplier finished outside the wait state");

	a_valid_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(st_q) == ST_DECIDE)
		else $error("result raised without a decide step");

	a_track_from_decide: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(tracked_x_q) || !$stable(tracked_y_q) |-> $past(st_q) == ST_DECIDE)
		else $error("tracked center changed outside a decide step");

	a_open_between: assert property (@(posedge clk) disable iff (!arst_n)
		$past(state_q.gesture) != GES_OPEN && !$stable(state_q.gesture)
			|-> state_q.gesture == GES_OPEN)
		else $error("gesture left a non-open value without passing through open");
`endif

endmodule

>>> sim/hand_gesture_state_classifier_core_tb.sv
// testbench for the hand gesture state classifier: random and directed frames, checked against a predictor
module hand_gesture_state_classifier_core_tb import hgsc_pkg::*;;

	localparam int COORD_W = 11;
	localparam int SETTLE_CYCLES = 110;
	localparam int STALL_LIMIT = 4000;
	localparam int PHASE_FRAMES = 150;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic [COORD_W-1:0]  x;
		logic [COORD_W-1:0]  y;
		logic [RADIUS_W-1:0] radius;
		logic [2:0]          count;
		logic [COORD_W-1:0]  ha;
		logic [COORD_W-1:0]  hb;
		logic [COORD_W-1:0]  hc;
	} frame_t;

	typedef struct packed {
		gesture_t           gesture;
		motion_t            motion;
		logic [COORD_W-1:0] tx;
		logic [COORD_W-1:0] ty;
		logic [1:0]         top;
		logic [1:0]         low;
	} gesture_result_t;

	class gesture_scoreboard;
		logic [RATIO_W-1:0] move_ratio;
		logic [RATIO_W-1:0] still_ratio;
		logic [RATIO_W-1:0] pinch_ratio;
		logic [COORD_W-1:0] cur_x;
		logic [COORD_W-1:0] cur_y;
		motion_t            cur_motion;
		gesture_t           cur_gesture;
		logic [1:0]         cur_top;
		logic [1:0]         cur_low;
		gesture_result_t    pending_results[$];
		int                 mismatches;
		int                 frames;
		int                 checked;

		function new();
			move_ratio = MOVE_RATIO_RST;
			still_ratio = STILL_RATIO_RST;
			pinch_ratio = PINCH_RATIO_RST;
			cur_x = '0;
			cur_y = '0;
			cur_motion = MOT_MOVE;
			cur_gesture = GES_OPEN;
			cur_top = '0;
			cur_low = '0;
			mismatches = 0;
			frames = 0;
			checked = 0;
		endfunction

		function void set_ratio(logic [1:0] idx, logic [RATIO_W-1:0] val);
			case (idx)
				CFG_MOVE_RATIO: move_ratio = val;
				CFG_STILL_RATIO: still_ratio = val;
				CFG_PINCH_RATIO: pinch_ratio = val;
				default: ;
			endcase
		endfunction

		function void note_frame(frame_t f);
			logic [63:0]        dx;
			logic [63:0]        dy;
			logic [63:0]        d2;
			logic [63:0]        thr;
			logic [63:0]        limit;
			logic [63:0]        spread;
			logic [COORD_W-1:0] h[3];
			logic               still;
			int                 hi;
			int                 lo;
			int                 i;
			gesture_t           cand;
			gesture_result_t    r;
			dx = (f.x > cur_x) ? 64'(f.x - cur_x) : 64'(cur_x - f.x);
			dy = (f.y > cur_y) ? 64'(f.y - cur_y) : 64'(cur_y - f.y);
			d2 = dx * dx + dy * dy;
			thr = 64'(f.radius) * 64'(cur_motion == MOT_MOVE ? move_ratio : still_ratio);
			still = (d2 << DIST_SHIFT) < (thr * thr);
			if (!still) begin
				cur_x = f.x;
				cur_y = f.y;
			end
			if (cur_motion == MOT_STATION)
				cur_motion = still ? MOT_STATION : MOT_START;
			else
				cur_motion = still ? MOT_STATION : MOT_MOVE;
			cand = cur_gesture;
			if (cur_motion == MOT_STATION) begin
				limit = 64'(f.radius) * 64'(pinch_ratio);
				h[0] = f.ha;
				h[1] = f.hb;
				h[2] = f.hc;
				if (f.count >= OPEN_MIN_FINGERS) begin
					cand = GES_OPEN;
				end else if (f.count == 3'd0) begin
					cand = GES_CLOSED;
				end else if (f.count == 3'd1) begin
					cand = GES_POINTER;
					cur_top = 2'd0;
				end else begin
					if (f.count == 3'd2) begin
						hi = (h[0] > h[1]) ? 0 : 1;
						lo = 1 - hi;
					end else begin
						hi = 0;
						lo = 0;
						for (i = 1; i < 3; i++) begin
							if (h[i] > h[hi]) hi = i;
							if (h[i] < h[lo]) lo = i;
						end
					end
					cur_top = 2'(hi);
					cur_low = 2'(lo);
					spread = 64'(h[hi] - h[lo]);
					cand = ((spread << RATIO_W) > limit) ? GES_PINCH : GES_SCROLL;
				end
			end
			if (cur_gesture != GES_OPEN && cand != cur_gesture)
				cand = GES_OPEN;
			cur_gesture = cand;
			r.gesture = cur_gesture;
			r.motion = cur_motion;
			r.tx = cur_x;
			r.ty = cur_y;
			r.top = cur_top;
			r.low = cur_low;
			pending_results.push_back(r);
			frames++;
		endfunction

		function void check_result(logic [2:0] g, logic [1:0] m, logic [COORD_W-1:0] tx,
				logic [COORD_W-1:0] ty, logic [1:0] top, logic [1:0] low);
			gesture_result_t want;
			if (pending_results.size() == 0) begin
				$error("result transfer with no frame pending");
				mismatches++;
				return;
			end
			want = pending_results.pop_front();
			checked++;
			if (g !== want.gesture) begin
				$error("gesture: expected %0d, actual %0d", want.gesture, g);
				mismatches++;
			end
			if (m !== want.motion) begin
				$error("motion: expected %0d, actual %0d", want.motion, m);
				mismatches++;
			end
			if (tx !== want.tx) begin
				$error("track_x: expected %0d, actual %0d", want.tx, tx);
				mismatches++;
			end
			if (ty !== want.ty) begin
				$error("track_y: expected %0d, actual %0d", want.ty, ty);
				mismatches++;
			end
			if (top !== want.top) begin
				$error("top_finger: expected %0d, actual %0d", want.top, top);
				mismatches++;
			end
			if (low !== want.low) begin
				$error("low_finger: expected %0d, actual %0d", want.low, low);
				mismatches++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [COORD_W-1:0]    hand_x = '0;
	logic [COORD_W-1:0]    hand_y = '0;
	logic [RADIUS_W-1:0]   hand_radius = '0;
	logic [2:0]            finger_count = '0;
	logic [COORD_W-1:0]    height_a = '0;
	logic [COORD_W-1:0]    height_b = '0;
	logic [COORD_W-1:0]    height_c = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [2:0]            gesture;
	logic [1:0]            motion;
	logic [COORD_W-1:0]    track_x;
	logic [COORD_W-1:0]    track_y;
	logic [1:0]            top_finger;
	logic [1:0]            low_finger;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [1:0]            cfg_index = '0;
	logic [RATIO_W-1:0]    cfg_data = '0;

	gesture_scoreboard sb = new();
	bit                steady = 1'b0;
	int                idle_count = 0;
	logic [COORD_W-1:0] home_x = '0;
	logic [COORD_W-1:0] home_y = '0;
	logic [2:0]         home_count = 3'd1;

	hand_gesture_state_classifier_core #(
		.COORD_BITS(COORD_W)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.hand_x(hand_x),
		.hand_y(hand_y),
		.hand_radius(hand_radius),
		.finger_count(finger_count),
		.height_a(height_a),
		.height_b(height_b),
		.height_c(height_c),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.gesture(gesture),
		.motion(motion),
		.track_x(track_x),
		.track_y(track_y),
		.top_finger(top_finger),
		.low_finger(low_finger),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(0, 99) < 13);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(gesture, motion, track_x, track_y, top_finger, low_finger);
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_count <= 0;
		else
			idle_count <= idle_count + 1;
		if (idle_count >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	function automatic logic [COORD_W-1:0] clamp_coord(int v);
		if (v < 0) return '0;
		if (v > 2047) return '1;
		return COORD_W'(v);
	endfunction

	function automatic frame_t make_frame(int x, int y, int r, int c, int a, int b, int d);
		frame_t f;
		f.x = COORD_W'(x);
		f.y = COORD_W'(y);
		f.radius = RADIUS_W'(r);
		f.count = 3'(c);
		f.ha = COORD_W'(a);
		f.hb = COORD_W'(b);
		f.hc = COORD_W'(d);
		return f;
	endfunction

	function automatic frame_t random_frame();
		frame_t f;
		int     pick;
		int     reach;
		int     base;
		int     r;
		pick = $urandom_range(0, 99);
		if (pick < 6) f.radius = '0;
		else if (pick < 12) f.radius = '1;
		else if (pick < 30) f.radius = RADIUS_W'($urandom_range(1, 63));
		else f.radius = RADIUS_W'($urandom_range(64, 1023));
		r = int'(f.radius);
		pick = $urandom_range(0, 99);
		if (pick < 12) begin
			home_x = COORD_W'($urandom);
			home_y = COORD_W'($urandom);
		end
		if (pick < 20) begin
			f.x = COORD_W'($urandom);
			f.y = COORD_W'($urandom);
		end else begin
			reach = r / int'($urandom_range(2, 16)) + 1;
			f.x = clamp_coord(int'(home_x) + int'($urandom_range(0, 2 * reach)) - reach);
			f.y = clamp_coord(int'(home_y) + int'($urandom_range(0, 2 * reach)) - reach);
		end
		if ($urandom_range(0, 99) < 20)
			home_count = 3'($urandom);
		f.count = home_count;
		if ($urandom_range(0, 1) == 0) begin
			f.ha = COORD_W'($urandom);
			f.hb = COORD_W'($urandom);
			f.hc = COORD_W'($urandom);
		end else begin
			base = int'($urandom_range(0, 2047));
			f.ha = clamp_coord(base + int'($urandom_range(0, r)));
			f.hb = clamp_coord(base + int'($urandom_range(0, r)));
			f.hc = clamp_coord(base + int'($urandom_range(0, r)));
		end
		if ($urandom_range(0, 99) < 10) f.hb = f.ha;
		if ($urandom_range(0, 99) < 10) f.hc = f.hb;
		return f;
	endfunction

	task automatic send_frame(frame_t f);
		if (!steady && $urandom_range(0, 99) < 13) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 200)) @(posedge clk);
		end
		in_valid <= 1'b1;
		hand_x <= f.x;
		hand_y <= f.y;
		hand_radius <= f.radius;
		finger_count <= f.count;
		height_a <= f.ha;
		height_b <= f.hb;
		height_c <= f.hc;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_frame(f);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_ratio(logic [1:0] idx, logic [RATIO_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_ratio(idx, val);
	endtask

	task automatic apply_ratios(logic [RATIO_W-1:0] mv, logic [RATIO_W-1:0] st,
			logic [RATIO_W-1:0] pn);
		drain_results();
		write_ratio(CFG_UNUSED, RATIO_W'($urandom));
		write_ratio(CFG_PINCH_RATIO, pn);
		write_ratio(CFG_MOVE_RATIO, mv);
		write_ratio(CFG_STILL_RATIO, st);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int phase;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset ratios: zero radius, closed, pass through open, ties, extremes
		send_frame(make_frame(0, 0, 0, 0, 0, 0, 0));
		send_frame(make_frame(0, 0, 1023, 0, 0, 0, 0));
		send_frame(make_frame(0, 0, 1023, 1, 0, 0, 0));
		send_frame(make_frame(0, 0, 1023, 1, 0, 0, 0));
		send_frame(make_frame(0, 0, 1023, 2, 2047, 0, 0));
		send_frame(make_frame(0, 0, 1023, 2, 2047, 0, 0));
		send_frame(make_frame(0, 0, 1023, 2, 500, 500, 0));
		send_frame(make_frame(0, 0, 1023, 2, 500, 500, 0));
		send_frame(make_frame(0, 0, 1023, 3, 2047, 2047, 0));
		send_frame(make_frame(0, 0, 1023, 3, 5, 5, 5));
		send_frame(make_frame(0, 0, 1023, 3, 5, 5, 5));
		send_frame(make_frame(0, 0, 1023, 3, 0, 2047, 1000));
		send_frame(make_frame(0, 0, 1023, 7, 2047, 2047, 2047));
		send_frame(make_frame(0, 0, 1023, 4, 0, 2047, 1000));
		send_frame(make_frame(2047, 2047, 1023, 0, 0, 0, 0));
		send_frame(make_frame(2047, 2047, 1023, 0, 0, 0, 0));
		send_frame(make_frame(1000, 1000, 1, 3, 1000, 1000, 1001));
		send_frame(make_frame(0, 2047, 1023, 2, 100, 200, 0));
		send_frame(make_frame(100, 2000, 1023, 2, 100, 200, 0));
		send_frame(make_frame(100, 2000, 1023, 2, 100, 200, 0));
		send_frame(make_frame(2047, 2047, 1023, 7, 2047, 2047, 2047));

		for (phase = 0; phase < 9; phase++) begin
			steady = (phase == 1);
			case (phase)
				0: apply_ratios(MOVE_RATIO_RST, STILL_RATIO_RST, PINCH_RATIO_RST);
				1: apply_ratios(8'd255, 8'd255, 8'd255);
				2: apply_ratios(8'd0, 8'd0, 8'd0);
				3: apply_ratios(8'd255, 8'd0, 8'd0);
				4: apply_ratios(8'd0, 8'd255, 8'd255);
				8: apply_ratios(MOVE_RATIO_RST, STILL_RATIO_RST, PINCH_RATIO_RST);
				default: apply_ratios(RATIO_W'($urandom), RATIO_W'($urandom),
					RATIO_W'($urandom));
			endcase
			repeat (PHASE_FRAMES) send_frame(random_frame());
		end
		steady = 1'b0;
		drain_results();

		$display("tb: %0d frames, %0d results checked, %0d mismatches", sb.frames, sb.checked,
			sb.mismatches);
		$display("tb: nine ratio settings incl. all-zero and all-max, with random stalls");
		if (sb.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
